FILE: rtl/core/jacobi_five_point_stencil_assert.svh
// Assertion macros for the five-point stencil block.
`ifndef JACOBI_FIVE_POINT_STENCIL_ASSERT_SVH
`define JACOBI_FIVE_POINT_STENCIL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JFPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JFPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/jacobi5_pkg.sv
// Shared constants and types of the five-point stencil block.
package jacobi5_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 30;
    localparam int GRID_ROWS = 128;
    localparam int GRID_COLS = 128;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int IDX_W     = 7;

    // operand queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    // datapath widths
    localparam int PAIR_W = DATA_W + 1;
    localparam int PROD_W = PAIR_W + DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SH_W   = SUM_W - FRAC_W;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration map
    localparam int ADDR_W = 4;
    localparam int RIDX_W = ADDR_W - 2;
    localparam logic [RIDX_W-1:0] REG_COEF_X   = 2'd0;
    localparam logic [RIDX_W-1:0] REG_COEF_Y   = 2'd1;
    localparam logic [RIDX_W-1:0] REG_COEF_SRC = 2'd2;

    localparam logic signed [DATA_W-1:0] COEF_X_RST   = 32'sd268435456;
    localparam logic signed [DATA_W-1:0] COEF_Y_RST   = 32'sd268435456;
    localparam logic signed [DATA_W-1:0] COEF_SRC_RST = -32'sd16643;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } meta_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] up;
        logic signed [DATA_W-1:0] down;
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;
        logic signed [DATA_W-1:0] src;
        meta_t                    meta;
    } q_entry_t;

    typedef struct packed {
        logic [Q_LVL_W-1:0] level;
        logic               full;
        logic               empty;
    } q_stat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
        logic signed [DATA_W-1:0] cb;
    } coef_t;

endpackage

FILE: rtl/core/jacobi5_front.sv
// Front end: raster counters, line buffers, neighbor window, interior test.
module jacobi5_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [jacobi5_pkg::DATA_W-1:0]  cur_value,
    input  logic signed [jacobi5_pkg::DATA_W-1:0]  src_value,
    input  jacobi5_pkg::q_stat_t                   q_stat,
    output logic                                   q_push,
    output jacobi5_pkg::q_entry_t                  q_data
);

    localparam int DATA_W = jacobi5_pkg::DATA_W;
    localparam int ROW_W  = jacobi5_pkg::ROW_W;
    localparam int COL_W  = jacobi5_pkg::COL_W;
    localparam int IDX_W  = jacobi5_pkg::IDX_W;
    localparam int LVL1_W = jacobi5_pkg::Q_LVL_W + 1;
    localparam int ROWS   = jacobi5_pkg::GRID_ROWS;
    localparam int COLS   = jacobi5_pkg::GRID_COLS;

    logic signed [DATA_W-1:0] even_mem [COLS];
    logic signed [DATA_W-1:0] odd_mem  [COLS];
    logic signed [DATA_W-1:0] src_mem  [COLS];

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic                     accept;
    logic                     here_par;
    logic                     last_col;
    logic                     interior;
    logic [COL_W-1:0]         addr_here;
    logic [COL_W-1:0]         addr_other;
    logic [COL_W-1:0]         even_addr;
    logic [COL_W-1:0]         odd_addr;
    jacobi5_pkg::meta_t       meta;

    logic signed [DATA_W-1:0] even_rd_reg;
    logic signed [DATA_W-1:0] odd_rd_reg;
    logic signed [DATA_W-1:0] src_rd_reg;

    logic                     s1_valid_reg;
    logic                     s1_emit_reg;
    logic                     s1_par_reg;
    logic                     s1_wrap_reg;
    logic signed [DATA_W-1:0] s1_down_reg;
    jacobi5_pkg::meta_t       s1_meta_reg;

    logic signed [DATA_W-1:0] up_val;
    logic signed [DATA_W-1:0] other_val;
    logic signed [DATA_W-1:0] mid_new;
    logic signed [DATA_W-1:0] w1_reg;
    logic signed [DATA_W-1:0] w2_reg;

    // room for this request plus the one still in stage 1
    assign full = (LVL1_W'(q_stat.level) + LVL1_W'(s1_emit_reg))
                  >= LVL1_W'(jacobi5_pkg::Q_DEPTH);
    assign accept = push && !full;

    assign here_par = row_reg[0];
    assign last_col = (col_reg == COL_W'(COLS - 1));
    assign interior = (row_reg >= ROW_W'(2)) && (col_reg != '0)
                      && (col_reg <= COL_W'(COLS - 2));

    // row i buffer: read up at j, or next row's first left at end of row
    // row i-1 buffer: read the right neighbor at j+1
    assign addr_here  = last_col ? '0 : col_reg;
    assign addr_other = last_col ? '0 : col_reg + COL_W'(1);
    assign even_addr  = here_par ? addr_other : addr_here;
    assign odd_addr   = here_par ? addr_here : addr_other;

    always_comb
    begin
        meta.row  = IDX_W'(row_reg - ROW_W'(1));
        meta.col  = IDX_W'(col_reg);
        meta.last = (row_reg == ROW_W'(ROWS - 1)) && (col_reg == COL_W'(COLS - 2));
    end

    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && interior;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // line buffers, read before write at the same address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!here_par)
            begin
                even_mem[col_reg] <= cur_value;
            end
            even_rd_reg <= even_mem[even_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (here_par)
            begin
                odd_mem[col_reg] <= cur_value;
            end
            odd_rd_reg <= odd_mem[odd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_mem[col_reg] <= src_value;
            src_rd_reg       <= src_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_par_reg  <= here_par;
            s1_wrap_reg <= last_col;
            s1_down_reg <= cur_value;
            s1_meta_reg <= meta;
        end
    end

    assign up_val    = s1_par_reg ? odd_rd_reg : even_rd_reg;
    assign other_val = s1_par_reg ? even_rd_reg : odd_rd_reg;
    assign mid_new   = s1_wrap_reg ? up_val : other_val;

    // last two middle-row samples: w2 is the left neighbor
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            w2_reg <= w1_reg;
            w1_reg <= mid_new;
        end
    end

    assign q_push = s1_emit_reg;

    always_comb
    begin
        q_data.up    = up_val;
        q_data.down  = s1_down_reg;
        q_data.left  = w2_reg;
        q_data.right = mid_new;
        q_data.src   = src_rd_reg;
        q_data.meta  = s1_meta_reg;
    end

endmodule

FILE: rtl/core/jacobi5_queue.sv
// Operand queue between the front end and the arithmetic back end.
module jacobi5_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  jacobi5_pkg::q_entry_t push_data,
    input  logic                  pop,
    output jacobi5_pkg::q_entry_t pop_data,
    output jacobi5_pkg::q_stat_t  stat
);

    localparam int DEPTH = jacobi5_pkg::Q_DEPTH;
    localparam int PTR_W = jacobi5_pkg::Q_PTR_W;
    localparam int LVL_W = jacobi5_pkg::Q_LVL_W;

    jacobi5_pkg::q_entry_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.level = count_reg;
    assign stat.full  = (count_reg == LVL_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/jacobi5_back.sv
// Back end: pre-add, three multiplies, exact sum, floor shift and saturation.
module jacobi5_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  jacobi5_pkg::q_entry_t                  q_data,
    input  jacobi5_pkg::q_stat_t                   q_stat,
    output logic                                   q_pop,
    input  jacobi5_pkg::coef_t                     coef,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [jacobi5_pkg::DATA_W-1:0]  new_value,
    output logic [jacobi5_pkg::IDX_W-1:0]          row_index,
    output logic [jacobi5_pkg::IDX_W-1:0]          col_index,
    output logic                                   sweep_last,
    output logic                                   clipped
);

    localparam int DATA_W = jacobi5_pkg::DATA_W;
    localparam int FRAC_W = jacobi5_pkg::FRAC_W;
    localparam int PAIR_W = jacobi5_pkg::PAIR_W;
    localparam int PROD_W = jacobi5_pkg::PROD_W;
    localparam int SUM_W  = jacobi5_pkg::SUM_W;
    localparam int SH_W   = jacobi5_pkg::SH_W;

    logic a_valid_reg, b_valid_reg, c_valid_reg, o_valid_reg;
    logic a_ready, b_ready, c_ready, o_ready;

    logic signed [PAIR_W-1:0] a_ud_reg;
    logic signed [PAIR_W-1:0] a_lr_reg;
    logic signed [DATA_W-1:0] a_src_reg;
    jacobi5_pkg::meta_t       a_meta_reg;

    logic signed [PROD_W-1:0] b_ud_reg;
    logic signed [PROD_W-1:0] b_lr_reg;
    logic signed [PROD_W-1:0] b_src_reg;
    jacobi5_pkg::meta_t       b_meta_reg;

    logic signed [SUM_W-1:0]  c_sum_reg;
    jacobi5_pkg::meta_t       c_meta_reg;

    logic signed [SH_W-1:0]   sh_val;
    logic                     sat;
    logic signed [DATA_W-1:0] value_next;

    logic signed [DATA_W-1:0] o_value_reg;
    jacobi5_pkg::meta_t       o_meta_reg;
    logic                     o_clip_reg;

    // elastic chain: a stage loads when it is empty or drains this cycle
    assign o_ready = !o_valid_reg || pop;
    assign c_ready = !c_valid_reg || o_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign q_pop   = a_ready && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= !q_stat.empty;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_ud_reg   <= PAIR_W'(q_data.up) + PAIR_W'(q_data.down);
            a_lr_reg   <= PAIR_W'(q_data.left) + PAIR_W'(q_data.right);
            a_src_reg  <= q_data.src;
            a_meta_reg <= q_data.meta;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_ud_reg   <= PROD_W'(a_ud_reg) * PROD_W'(coef.cx);
            b_lr_reg   <= PROD_W'(a_lr_reg) * PROD_W'(coef.cy);
            b_src_reg  <= PROD_W'(a_src_reg) * PROD_W'(coef.cb);
            b_meta_reg <= a_meta_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_sum_reg  <= SUM_W'(b_ud_reg) + SUM_W'(b_lr_reg) + SUM_W'(b_src_reg);
            c_meta_reg <= b_meta_reg;
        end
    end

    // dropping the fraction bits of the exact sum is a floor shift
    assign sh_val = c_sum_reg[SUM_W-1:FRAC_W];
    assign sat    = !((&sh_val[SH_W-1:DATA_W-1]) || !(|sh_val[SH_W-1:DATA_W-1]));

    always_comb
    begin
        if (!sat)
        begin
            value_next = sh_val[DATA_W-1:0];
        end
        else if (sh_val[SH_W-1])
        begin
            value_next = jacobi5_pkg::SAT_MIN;
        end
        else
        begin
            value_next = jacobi5_pkg::SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && c_valid_reg)
        begin
            o_value_reg <= value_next;
            o_clip_reg  <= sat;
            o_meta_reg  <= c_meta_reg;
        end
    end

    assign empty      = !o_valid_reg;
    assign new_value  = o_value_reg;
    assign row_index  = o_meta_reg.row;
    assign col_index  = o_meta_reg.col;
    assign sweep_last = o_meta_reg.last;
    assign clipped    = o_clip_reg;

endmodule

FILE: rtl/core/jacobi_five_point_stencil.sv
// Top level of the streaming five-point Jacobi stencil with its register port.
//
// Input requests: grid points in raster order, row by row, columns 0 to 127,
// each with cur_value and src_value (signed Q1.30). A request is taken at a
// rising edge with push high and full low. Every point of row i >= 2 with
// 1 <= j <= 126 yields one result request, the new value of point (i-1, j);
// other points yield none. Results leave oldest first: new_value, row_index,
// col_index, sweep_last (last interior point of the sweep) and clipped
// (saturated); a result is taken at an edge with pop high and empty low.
// A result passes front stage 1, the operand queue and back stages a, b, c, o.
// Throughput: one request per cycle while full is low, limited by the single
// write and read port of each line buffer and the 4-entry operand queue.
// When pop is held low the back end fills, then the operand queue; full
// rises once the queue cannot hold the requests already in flight.
// Reset clears the raster position to (0, 0), empties the pipeline and
// queue, and loads the default weights; line buffers are not cleared.
// Registers (APB, 32 bit): coef_x at 0x0, coef_y at 0x4, coef_src at 0x8.
`include "jacobi_five_point_stencil_assert.svh"

module jacobi_five_point_stencil (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input queue side
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [jacobi5_pkg::DATA_W-1:0]  cur_value,
    input  logic signed [jacobi5_pkg::DATA_W-1:0]  src_value,
    // result queue side
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [jacobi5_pkg::DATA_W-1:0]  new_value,
    output logic [jacobi5_pkg::IDX_W-1:0]          row_index,
    output logic [jacobi5_pkg::IDX_W-1:0]          col_index,
    output logic                                   sweep_last,
    output logic                                   clipped,
    // register port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [jacobi5_pkg::ADDR_W-1:0]         paddr,
    input  logic [jacobi5_pkg::DATA_W-1:0]         pwdata,
    output logic [jacobi5_pkg::DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int DATA_W = jacobi5_pkg::DATA_W;
    localparam int ADDR_W = jacobi5_pkg::ADDR_W;
    localparam int RIDX_W = jacobi5_pkg::RIDX_W;

    logic signed [DATA_W-1:0] coef_x_reg;
    logic signed [DATA_W-1:0] coef_y_reg;
    logic signed [DATA_W-1:0] coef_src_reg;

    logic              cfg_write;
    logic [RIDX_W-1:0] cfg_idx;

    jacobi5_pkg::coef_t    coef;
    jacobi5_pkg::q_entry_t q_in;
    jacobi5_pkg::q_entry_t q_out;
    jacobi5_pkg::q_stat_t  q_stat;
    logic                  q_push;
    logic                  q_pop;

    logic                  last_at_corner;
    logic                  clip_at_rail;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg   <= jacobi5_pkg::COEF_X_RST;
            coef_y_reg   <= jacobi5_pkg::COEF_Y_RST;
            coef_src_reg <= jacobi5_pkg::COEF_SRC_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                jacobi5_pkg::REG_COEF_X:   coef_x_reg   <= pwdata;
                jacobi5_pkg::REG_COEF_Y:   coef_y_reg   <= pwdata;
                jacobi5_pkg::REG_COEF_SRC: coef_src_reg <= pwdata;
                default:                   ;  // unmapped: write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            jacobi5_pkg::REG_COEF_X:   prdata = coef_x_reg;
            jacobi5_pkg::REG_COEF_Y:   prdata = coef_y_reg;
            jacobi5_pkg::REG_COEF_SRC: prdata = coef_src_reg;
            default:                   prdata = '0;
        endcase
    end

    assign coef.cx = coef_x_reg;
    assign coef.cy = coef_y_reg;
    assign coef.cb = coef_src_reg;

    // ---------------- datapath ----------------
    // front: raster position, line buffers, left/right window, interior test
    jacobi5_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cur_value (cur_value),
        .src_value (src_value),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // operand sets of interior points waiting for the arithmetic
    jacobi5_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    // back: weighted sum, floor shift, saturate, output register
    jacobi5_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_out),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .coef       (coef),
        .empty      (empty),
        .pop        (pop),
        .new_value  (new_value),
        .row_index  (row_index),
        .col_index  (col_index),
        .sweep_last (sweep_last),
        .clipped    (clipped)
    );

    // ---------------- assertions ----------------
    assign last_at_corner = (row_index == 7'(jacobi5_pkg::GRID_ROWS - 2))
                            && (col_index == 7'(jacobi5_pkg::GRID_COLS - 2));
    assign clip_at_rail   = (new_value == jacobi5_pkg::SAT_MAX)
                            || (new_value == jacobi5_pkg::SAT_MIN);

    `JFPS_ASSERT_NOW(a_queue_no_overflow, q_push, !q_stat.full, "operand queue overflow")
    `JFPS_ASSERT_NOW(a_queue_no_underrun, q_pop, !q_stat.empty, "operand queue underrun")
    `JFPS_ASSERT_NEXT(a_queue_fills, q_push, !q_stat.empty, "pushed request lost")
    `JFPS_ASSERT_NOW(a_last_position, !empty && sweep_last, last_at_corner, "sweep_last misplaced")
    `JFPS_ASSERT_NOW(a_clip_value, !empty && clipped, clip_at_rail, "clipped result off rail")

endmodule
